[hw/rtl/bab_pkg.sv]
package bab_pkg;

    // One row of the block table
    typedef struct packed {
        logic        valid;
        logic [31:0] start;
        logic [32:0] length;
    } entry_t;

    // Request kinds carried on the input tuser; any other code is an access check
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;

    // Result status carried on the output tuser
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_ZERO_SIZE     = 3'd1,
        ST_NO_MEMORY     = 3'd2,
        ST_BAD_FREE      = 3'd3,
        ST_NO_BLOCK      = 3'd4,
        ST_OUT_OF_BOUNDS = 3'd5,
        ST_TABLE_FULL    = 3'd6
    } status_t;

    localparam logic [31:0] HEAP_SIZE_RESET = 32'd65536;

endpackage

[hw/rtl/bab_cell.sv]
module bab_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  bab_pkg::entry_t entry_in,
    output bab_pkg::entry_t entry_out
);
    import bab_pkg::*;

    logic        valid_reg;
    logic [31:0] start_reg;
    logic [32:0] length_reg;

    // Take the neighbor's entry on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= entry_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            start_reg  <= entry_in.start;
            length_reg <= entry_in.length;
        end
    end

    assign entry_out = '{valid: valid_reg, start: start_reg, length: length_reg};

endmodule

[hw/rtl/bab_rem.sv]
module bab_rem #(
    parameter int ALIGN_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] size,
    output logic        done,
    output logic [32:0] rsize
);
    import bab_pkg::*;

    generate
        if ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0)
        begin : g_pow2
            localparam logic [32:0] LOW_MASK = 33'(ALIGN_BYTES - 1);

            logic        done_reg;
            logic [32:0] rsize_reg;

            // Round up by add and mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else if (start)
                begin
                    done_reg <= 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rsize_reg <= ({1'b0, size} + LOW_MASK) & ~LOW_MASK;
                end
            end

            assign done  = done_reg;
            assign rsize = rsize_reg;
        end
        else
        begin : g_div
            localparam int RW     = $clog2(ALIGN_BYTES + 1);
            localparam int TW     = RW + 8;
            localparam int CHUNKS = 32 / 8;
            localparam logic [TW-1:0] ALIGN_T = TW'(ALIGN_BYTES);
            localparam logic [1:0]    LAST    = 2'(CHUNKS - 1);

            logic          busy_reg;
            logic          fin_reg;
            logic          done_reg;
            logic [1:0]    cnt_reg;
            logic [RW-1:0] rem_reg;
            logic [RW-1:0] rem_next;
            logic [31:0]   shift_reg;
            logic [31:0]   size_reg;
            logic [32:0]   rsize_reg;
            logic [TW-1:0] part;

            // Fold in one byte of the size, most significant first
            always_comb
            begin
                part = {rem_reg, shift_reg[31:24]};
                for (int k = 7; k >= 0; k--)
                begin
                    if (part >= (ALIGN_T << k))
                    begin
                        part = part - (ALIGN_T << k);
                    end
                end
                rem_next = part[RW-1:0];
            end

            // Sequence the byte steps, then one rounding step
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else if (start)
                begin
                    busy_reg <= 1'b1;
                    fin_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else if (busy_reg)
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == LAST)
                    begin
                        busy_reg <= 1'b0;
                        fin_reg  <= 1'b1;
                    end
                end
                else if (fin_reg)
                begin
                    fin_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg   <= '0;
                    shift_reg <= size;
                    size_reg  <= size;
                end
                else if (busy_reg)
                begin
                    rem_reg   <= rem_next;
                    shift_reg <= {shift_reg[23:0], 8'd0};
                end
                else if (fin_reg)
                begin
                    if (rem_reg == '0)
                    begin
                        rsize_reg <= {1'b0, size_reg};
                    end
                    else
                    begin
                        rsize_reg <= {1'b0, size_reg}
                                     + (33'(ALIGN_BYTES) - 33'(rem_reg));
                    end
                end
            end

            assign done  = done_reg;
            assign rsize = rsize_reg;
        end
    endgenerate

endmodule

[hw/rtl/bump_allocator_bounds_checker.sv]
// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata[63:0] tuser  request: address, size / kind
// m_axis    out        tvalid tready tdata[31:0] tuser  result: alloc address / status
// cfg       in         valid ready data[31:0]           heap size register write
//
// One request is in flight at a time; a new one is taken only once the last result is loaded.
// The block table is a ring of cells that rotates once per request, one entry a cycle.
// With ALIGN_BYTES not a power of two every request also waits while the remainder is found byte by byte.
// A result waits in the output register while the next request is taken.
// Reset empties the table, clears the bump pointer and sets the heap size to 65536.
module bump_allocator_bounds_checker #(
    parameter int MAX_BLOCKS  = 16,
    parameter int ALIGN_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // req_address[31:0], req_size[63:32]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // alloc_address[31:0]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import bab_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS);
    localparam logic [CW-1:0] SCAN_LAST = CW'(MAX_BLOCKS - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CALC   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_FINISH = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] heap_size_reg;
    logic [32:0] next_free_reg;
    logic [1:0]  req_type_reg;
    logic [31:0] req_addr_reg;
    logic [31:0] req_size_reg;
    logic [32:0] req_end_reg;
    logic        zero_reg;
    logic        oom_reg;
    logic        alloc_en_reg;
    logic [31:0] alloc_addr_reg;
    logic [CW-1:0] scan_cnt_reg;
    logic        placed_reg;
    logic        hit_reg;
    logic        best_valid_reg;
    logic [31:0] best_start_reg;
    logic [32:0] best_len_reg;
    logic [33:0] best_end_reg;
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_addr_reg;

    logic        in_accept;
    logic        is_alloc;
    logic        is_free;
    logic        rem_done;
    logic [32:0] rsize;
    logic        load_out;
    logic        place_now;
    logic        free_now;
    logic        better;
    logic        oom;
    status_t     status_c;
    logic [31:0] addr_c;
    entry_t      head;
    entry_t      wb;
    entry_t      cell_q [MAX_BLOCKS];

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign is_alloc      = (req_type_reg == REQ_ALLOC);
    assign is_free       = (req_type_reg == REQ_FREE);
    assign load_out      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    // Round the size to the alignment
    bab_rem #(
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_rem (
        .clk  (clk),
        .rst_n(rst_n),
        .start(in_accept),
        .size (s_axis_tdata[63:32]),
        .done (rem_done),
        .rsize(rsize)
    );

    // Ring of table cells, rotating toward cell zero
    genvar gi;
    generate
        for (gi = 0; gi < MAX_BLOCKS; gi++)
        begin : g_cell
            entry_t cell_in;
            if (gi == MAX_BLOCKS - 1)
            begin : g_tail
                assign cell_in = wb;
            end
            else
            begin : g_mid
                assign cell_in = cell_q[gi + 1];
            end
            bab_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (state_reg == S_SCAN),
                .entry_in (cell_in),
                .entry_out(cell_q[gi])
            );
        end
    endgenerate

    // Examine the head cell and form its write-back
    always_comb
    begin
        head      = cell_q[0];
        place_now = alloc_en_reg && !placed_reg && !head.valid;
        free_now  = is_free && !hit_reg && head.valid && (head.start == req_addr_reg);
        better    = head.valid && (head.start <= req_addr_reg)
                    && (!best_valid_reg || (head.start > best_start_reg));
        wb        = head;
        if (place_now)
        begin
            wb = '{valid: 1'b1, start: next_free_reg[31:0], length: rsize};
        end
        if (free_now)
        begin
            wb.valid = 1'b0;
        end
    end

    assign oom = ({1'b0, next_free_reg} + {1'b0, rsize}) > {2'b00, heap_size_reg};

    // Advance the request sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (rem_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Pick the result status
    always_comb
    begin
        status_c = ST_OK;
        addr_c   = '0;
        if (is_alloc)
        begin
            priority if (zero_reg)
            begin
                status_c = ST_ZERO_SIZE;
            end
            else if (oom_reg)
            begin
                status_c = ST_NO_MEMORY;
            end
            else if (!placed_reg)
            begin
                status_c = ST_TABLE_FULL;
            end
            else
            begin
                addr_c = alloc_addr_reg;
            end
        end
        else if (is_free)
        begin
            if (!hit_reg)
            begin
                status_c = ST_BAD_FREE;
            end
        end
        else
        begin
            priority if (!best_valid_reg)
            begin
                status_c = ST_NO_BLOCK;
            end
            else if ({1'b0, req_end_reg} > best_end_reg)
            begin
                status_c = ST_OUT_OF_BOUNDS;
            end
            else
            begin
                status_c = ST_OK;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_size_reg  <= HEAP_SIZE_RESET;
            next_free_reg  <= '0;
            out_valid_reg  <= 1'b0;
            alloc_en_reg   <= 1'b0;
            placed_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            best_valid_reg <= 1'b0;
            scan_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                heap_size_reg <= cfg_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_CHECK)
            begin
                alloc_en_reg   <= is_alloc && (req_size_reg != '0) && !oom;
                placed_reg     <= 1'b0;
                hit_reg        <= 1'b0;
                best_valid_reg <= 1'b0;
                scan_cnt_reg   <= '0;
            end
            if (state_reg == S_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
                if (place_now)
                begin
                    placed_reg <= 1'b1;
                end
                if (free_now)
                begin
                    hit_reg <= 1'b1;
                end
                if (better)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
            // Bump the pointer once the block is recorded
            if ((state_reg == S_FINISH) && placed_reg)
            begin
                next_free_reg <= next_free_reg + rsize;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_type_reg <= s_axis_tuser;
            req_addr_reg <= s_axis_tdata[31:0];
            req_size_reg <= s_axis_tdata[63:32];
        end
        if (state_reg == S_CALC)
        begin
            req_end_reg <= {1'b0, req_addr_reg} + {1'b0, req_size_reg};
        end
        if (state_reg == S_CHECK)
        begin
            zero_reg       <= (req_size_reg == '0);
            oom_reg        <= oom;
            alloc_addr_reg <= next_free_reg[31:0];
        end
        if ((state_reg == S_SCAN) && better)
        begin
            best_start_reg <= head.start;
            best_len_reg   <= head.length;
        end
        if (state_reg == S_FINISH)
        begin
            best_end_reg <= {2'b00, best_start_reg} + {1'b0, best_len_reg};
        end
        if (load_out)
        begin
            out_status_reg <= status_c;
            out_addr_reg   <= addr_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = out_addr_reg;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    a_alloc_free_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(placed_reg && hit_reg))
        else $error("one scan both placed and freed an entry");

    a_pointer_moves_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FINISH) |=> $stable(next_free_reg))
        else $error("bump pointer changed outside the finish step");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result shown without a completed request");

    a_rounding_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> rem_done)
        else $error("allocation checked before rounding finished");
`endif

endmodule
